// ----- design/ldtm_pkg.sv -----
// Package for the lid delivery tamper monitor.
// Holds field widths, state and event codes, command codes and shared types.
// No dependencies.
package ldtm_pkg;

    localparam int LID_W   = 2;
    localparam int STATE_W = 3;
    localparam int CMD_W   = 2;
    localparam int TICKS_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int EV_W    = 3;
    localparam int TO_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TICKS = 1'd1;

    localparam logic [TICKS_W-1:0] OPEN_TICKS_RST  = 16'd500;
    localparam logic [TICKS_W-1:0] CLOSE_TICKS_RST = 16'd5000;

    // lid report codes
    localparam logic [LID_W-1:0] LID_NONE   = 2'd0;
    localparam logic [LID_W-1:0] LID_OPENED = 2'd1;
    localparam logic [LID_W-1:0] LID_CLOSED = 2'd2;

    // monitor states
    localparam logic [STATE_W-1:0] ST_CREATED        = 3'd0;
    localparam logic [STATE_W-1:0] ST_WAITING        = 3'd1;
    localparam logic [STATE_W-1:0] ST_SUSPECT_START  = 3'd2;
    localparam logic [STATE_W-1:0] ST_CONFIRM_START  = 3'd3;
    localparam logic [STATE_W-1:0] ST_SUSPECT_DONE   = 3'd4;
    localparam logic [STATE_W-1:0] ST_CONFIRM_DONE   = 3'd5;
    localparam logic [STATE_W-1:0] ST_SUSPECT_TAMPER = 3'd6;
    localparam logic [STATE_W-1:0] ST_CONFIRM_TAMPER = 3'd7;

    // events applied to the state table
    localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EV_W-1:0] EV_OPEN     = 3'd1;
    localparam logic [EV_W-1:0] EV_CLOSED   = 3'd2;
    localparam logic [EV_W-1:0] EV_OPEN_TO  = 3'd3;
    localparam logic [EV_W-1:0] EV_CLOSE_TO = 3'd4;

    // pending timeout codes
    localparam logic [TO_W-1:0] TO_IDLE  = 2'd0;
    localparam logic [TO_W-1:0] TO_OPEN  = 2'd1;
    localparam logic [TO_W-1:0] TO_CLOSE = 2'd2;

    // command codes
    localparam logic [CMD_W-1:0] LED_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] LED_FLASH   = 2'd1;
    localparam logic [CMD_W-1:0] LED_STEADY  = 2'd2;
    localparam logic [CMD_W-1:0] ALARM_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] ALARM_OPEN  = 2'd1;
    localparam logic [CMD_W-1:0] ALARM_DONE  = 2'd2;
    localparam logic [CMD_W-1:0] DISP_NONE   = 2'd0;
    localparam logic [CMD_W-1:0] DISP_BUSY   = 2'd1;
    localparam logic [CMD_W-1:0] DISP_DONE   = 2'd2;
    localparam logic [CMD_W-1:0] DISP_TAMPER = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] mon;
        logic [TICKS_W-1:0] count;
        logic [TO_W-1:0]    pending;
        logic               led;
    } ldtm_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] delivery_led;
        logic [CMD_W-1:0] alarm;
        logic [CMD_W-1:0] display;
        logic             stopwatch;
        logic             moved;
    } ldtm_cmd_t;

    typedef struct packed {
        logic [TICKS_W-1:0] open_ticks;
        logic [TICKS_W-1:0] close_ticks;
    } ldtm_cfg_t;

endpackage

// ----- design/ldtm_if.sv -----
// Handshake channels of the lid delivery tamper monitor: lid items in,
// status items out. Depends on ldtm_pkg.
interface ldtm_lid_if;
    logic                     valid;
    logic                     ready;
    logic [ldtm_pkg::LID_W-1:0] lid_event;
    logic                     tick;

    modport source (output valid, output lid_event, output tick, input ready);
    modport sink   (input valid, input lid_event, input tick, output ready);
endinterface

interface ldtm_status_if;
    logic                         valid;
    logic                         ready;
    logic [ldtm_pkg::STATE_W-1:0] arrival_state;
    logic                         white_led;
    logic                         transitioned;
    logic [ldtm_pkg::CMD_W-1:0]   delivery_led_cmd;
    logic [ldtm_pkg::CMD_W-1:0]   alarm_cmd;
    logic [ldtm_pkg::CMD_W-1:0]   display_cmd;
    logic                         stopwatch_start;

    modport source (output valid, output arrival_state, output white_led,
                    output transitioned, output delivery_led_cmd, output alarm_cmd,
                    output display_cmd, output stopwatch_start, input ready);
    modport sink   (input valid, input arrival_state, input white_led,
                    input transitioned, input delivery_led_cmd, input alarm_cmd,
                    input display_cmd, input stopwatch_start, output ready);
endinterface

// ----- design/ldtm_core.sv -----
// Combinational step of the lid monitor: lid report, then countdown and expiry.
// Depends on ldtm_pkg.
module ldtm_core
(
    input  ldtm_pkg::ldtm_state_t            cur,
    input  ldtm_pkg::ldtm_cfg_t              cfg,
    input  logic [ldtm_pkg::LID_W-1:0]       lid_event,
    input  logic                             tick,
    output ldtm_pkg::ldtm_state_t            nxt,
    output ldtm_pkg::ldtm_cmd_t              cmd
);

    typedef struct packed {
        ldtm_pkg::ldtm_state_t st;
        ldtm_pkg::ldtm_cmd_t   cmd;
    } work_t;

    function automatic work_t apply_event(work_t w, logic [ldtm_pkg::EV_W-1:0] ev,
                                          ldtm_pkg::ldtm_cfg_t c);
        work_t                        r;
        logic [ldtm_pkg::STATE_W-1:0] nx;
        logic                         go;
        r  = w;
        nx = w.st.mon;
        go = 1'b0;
        case (w.st.mon)
            ldtm_pkg::ST_CREATED:
            begin
                if (ev == ldtm_pkg::EV_OPEN) begin go = 1'b1; nx = ldtm_pkg::ST_SUSPECT_START; end
                if (ev == ldtm_pkg::EV_CLOSED) begin go = 1'b1; nx = ldtm_pkg::ST_WAITING; end
            end
            ldtm_pkg::ST_WAITING:
            begin
                if (ev == ldtm_pkg::EV_OPEN) begin go = 1'b1; nx = ldtm_pkg::ST_SUSPECT_START; end
            end
            ldtm_pkg::ST_SUSPECT_START:
            begin
                if (ev == ldtm_pkg::EV_CLOSED) begin go = 1'b1; nx = ldtm_pkg::ST_WAITING; end
                if (ev == ldtm_pkg::EV_OPEN_TO) begin go = 1'b1; nx = ldtm_pkg::ST_CONFIRM_START; end
            end
            ldtm_pkg::ST_CONFIRM_START:
            begin
                if (ev == ldtm_pkg::EV_CLOSED) begin go = 1'b1; nx = ldtm_pkg::ST_SUSPECT_DONE; end
            end
            ldtm_pkg::ST_SUSPECT_DONE:
            begin
                if (ev == ldtm_pkg::EV_CLOSE_TO) begin go = 1'b1; nx = ldtm_pkg::ST_CONFIRM_DONE; end
            end
            ldtm_pkg::ST_CONFIRM_DONE:
            begin
                if (ev == ldtm_pkg::EV_OPEN) begin go = 1'b1; nx = ldtm_pkg::ST_SUSPECT_TAMPER; end
            end
            ldtm_pkg::ST_SUSPECT_TAMPER:
            begin
                if (ev == ldtm_pkg::EV_CLOSED) begin go = 1'b1; nx = ldtm_pkg::ST_CONFIRM_DONE; end
                if (ev == ldtm_pkg::EV_OPEN_TO) begin go = 1'b1; nx = ldtm_pkg::ST_CONFIRM_TAMPER; end
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
        if (go) begin
            r.st.mon    = nx;
            r.cmd.moved = 1'b1;
            r.st.led    = 1'b0;
            case (nx)
                ldtm_pkg::ST_WAITING:
                begin
                    r.st.pending = ldtm_pkg::TO_IDLE;
                    r.st.count   = '0;
                end
                ldtm_pkg::ST_SUSPECT_START, ldtm_pkg::ST_SUSPECT_TAMPER:
                begin
                    r.st.led     = 1'b1;
                    r.st.pending = ldtm_pkg::TO_OPEN;
                    r.st.count   = c.open_ticks;
                end
                ldtm_pkg::ST_CONFIRM_START:
                begin
                    r.st.led            = 1'b1;
                    r.cmd.delivery_led  = ldtm_pkg::LED_FLASH;
                    r.cmd.alarm         = ldtm_pkg::ALARM_OPEN;
                    r.cmd.display       = ldtm_pkg::DISP_BUSY;
                end
                ldtm_pkg::ST_SUSPECT_DONE:
                begin
                    r.st.pending = ldtm_pkg::TO_CLOSE;
                    r.st.count   = c.close_ticks;
                end
                ldtm_pkg::ST_CONFIRM_DONE:
                begin
                    r.cmd.stopwatch     = 1'b1;
                    r.cmd.delivery_led  = ldtm_pkg::LED_STEADY;
                    r.cmd.alarm         = ldtm_pkg::ALARM_DONE;
                    r.cmd.display       = ldtm_pkg::DISP_DONE;
                end
                ldtm_pkg::ST_CONFIRM_TAMPER:
                begin
                    r.st.led            = 1'b1;
                    r.cmd.delivery_led  = ldtm_pkg::LED_FLASH;
                    r.cmd.alarm         = ldtm_pkg::ALARM_OPEN;
                    r.cmd.display       = ldtm_pkg::DISP_TAMPER;
                end
                default:
                begin
                    r.st.led = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    work_t                        w0;
    work_t                        w1;
    work_t                        w2;
    logic [ldtm_pkg::EV_W-1:0]    lid_ev;
    logic [ldtm_pkg::EV_W-1:0]    to_ev;

    always_comb
    begin
        w0.st  = cur;
        w0.cmd = '0;
        case (lid_event)
            ldtm_pkg::LID_OPENED: lid_ev = ldtm_pkg::EV_OPEN;
            ldtm_pkg::LID_CLOSED: lid_ev = ldtm_pkg::EV_CLOSED;
            default:              lid_ev = ldtm_pkg::EV_NONE;
        endcase
        w1 = apply_event(w0, lid_ev, cfg);

        to_ev = (w1.st.pending == ldtm_pkg::TO_OPEN) ? ldtm_pkg::EV_OPEN_TO
                                                     : ldtm_pkg::EV_CLOSE_TO;
        w2 = w1;
        if (tick && (w1.st.pending != ldtm_pkg::TO_IDLE)) begin
            if (w1.st.count <= 16'd1) begin
                w2.st.count   = '0;
                w2.st.pending = ldtm_pkg::TO_IDLE;
                w2 = apply_event(w2, to_ev, cfg);
            end else begin
                w2.st.count = w1.st.count - 16'd1;
            end
        end
        nxt = w2.st;
        cmd = w2.cmd;
    end

endmodule

// ----- design/lid_delivery_tamper_monitor.sv -----
// Top level of the lid delivery tamper monitor: input register, state and
// config registers, result register. Depends on ldtm_pkg, ldtm_if, ldtm_core.
//
//  channel | dir | payload                                       | accept
//  lid     | in  | lid_event, tick                               | valid & ready
//  status  | out | arrival_state, white_led, transitioned, cmds   | valid & ready
//  cfg     | in  | cfg_index, cfg_data                           | cfg_we
//
// One item per cycle while status is not stalled; status valid follows the lid
// accept (input register, then the single-pass step into the result register).
// The monitor state advances when an item moves from the input register into
// the result register. A stalled status side holds the result; the input
// register still takes one more item. Reset clears state, countdown and
// config to their defaults; no clearing pass.
module lid_delivery_tamper_monitor
(
    input  logic                               clk,
    input  logic                               rst_n,
    ldtm_lid_if.sink                           lid,
    ldtm_status_if.source                      status,
    input  logic                               cfg_we,
    input  logic [ldtm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ldtm_pkg::TICKS_W-1:0]       cfg_data
);

    ldtm_pkg::ldtm_cfg_t          cfg_reg;
    ldtm_pkg::ldtm_state_t        st_reg;
    ldtm_pkg::ldtm_state_t        st_next;
    ldtm_pkg::ldtm_cmd_t          cmd_next;
    ldtm_pkg::ldtm_cmd_t          cmd_reg;

    logic                         in_valid_reg;
    logic [ldtm_pkg::LID_W-1:0]   lid_event_reg;
    logic                         tick_reg;
    logic                         out_valid_reg;
    logic [ldtm_pkg::STATE_W-1:0] state_out_reg;
    logic                         led_out_reg;
    logic                         advance;

    assign advance   = in_valid_reg && (!out_valid_reg || status.ready);
    assign lid.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.open_ticks  <= ldtm_pkg::OPEN_TICKS_RST;
            cfg_reg.close_ticks <= ldtm_pkg::CLOSE_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ldtm_pkg::CFG_OPEN_TICKS:  cfg_reg.open_ticks  <= cfg_data;
                ldtm_pkg::CFG_CLOSE_TICKS: cfg_reg.close_ticks <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (lid.ready) begin
            in_valid_reg <= lid.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lid.ready && lid.valid) begin
            lid_event_reg <= lid.lid_event;
            tick_reg      <= lid.tick;
        end
    end

    ldtm_core u_core
    (
        .cur       (st_reg),
        .cfg       (cfg_reg),
        .lid_event (lid_event_reg),
        .tick      (tick_reg),
        .nxt       (st_next),
        .cmd       (cmd_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg.mon     <= ldtm_pkg::ST_CREATED;
            st_reg.count   <= '0;
            st_reg.pending <= ldtm_pkg::TO_IDLE;
            st_reg.led     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end else if (status.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            state_out_reg <= st_next.mon;
            led_out_reg   <= st_next.led;
            cmd_reg       <= cmd_next;
        end
    end

    assign status.valid            = out_valid_reg;
    assign status.arrival_state    = state_out_reg;
    assign status.white_led        = led_out_reg;
    assign status.transitioned     = cmd_reg.moved;
    assign status.delivery_led_cmd = cmd_reg.delivery_led;
    assign status.alarm_cmd        = cmd_reg.alarm;
    assign status.display_cmd      = cmd_reg.display;
    assign status.stopwatch_start  = cmd_reg.stopwatch;

    // close countdown runs exactly while in suspect complete
    a_close_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mon == ldtm_pkg::ST_SUSPECT_DONE) == (st_reg.pending == ldtm_pkg::TO_CLOSE))
        else $error("close countdown out of step with state");

    a_pending_code: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.pending == ldtm_pkg::TO_IDLE) || (st_reg.pending == ldtm_pkg::TO_OPEN)
        || (st_reg.pending == ldtm_pkg::TO_CLOSE))
        else $error("bad pending timeout code");

    a_waiting_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.mon == ldtm_pkg::ST_WAITING) |-> (st_reg.pending == ldtm_pkg::TO_IDLE))
        else $error("countdown running in waiting");

    a_led_level: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.led == ((st_reg.mon == ldtm_pkg::ST_SUSPECT_START)
                    || (st_reg.mon == ldtm_pkg::ST_CONFIRM_START)
                    || (st_reg.mon == ldtm_pkg::ST_SUSPECT_TAMPER)
                    || (st_reg.mon == ldtm_pkg::ST_CONFIRM_TAMPER)))
        else $error("indicator level does not match state");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (status.valid && (status.arrival_state == st_reg.mon)))
        else $error("result register not loaded with new state");

endmodule
